@@ sv/rijndael_block_cipher_macros.svh @@
// Assertion macros shared by the cipher RTL.
`ifndef RIJNDAEL_BLOCK_CIPHER_MACROS_SVH
`define RIJNDAEL_BLOCK_CIPHER_MACROS_SVH
`ifndef ASSERT_OFF
// Property that must hold at every rising clock edge outside reset.
`define RBC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition in one cycle that forces a consequence in the next.
`define RBC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define RBC_ASSERT(lbl, clk, rstn, prop, msg)
`define RBC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

@@ sv/rbc_pkg.sv @@
// Types, constants, S-box tables and round functions of the Rijndael cipher.
package rbc_pkg;

    typedef logic [63:0]        t_word64;
    typedef logic [0:31][7:0]   t_state;
    typedef logic [0:7][31:0]   t_row;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_BSEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KSEL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY3 = 3'd5;

    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    localparam logic [1:0] SEL_128 = 2'd0;
    localparam logic [1:0] SEL_192 = 2'd1;

    localparam logic [0:255][7:0] SBOX = {
        128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
    };

    localparam logic [0:255][7:0] INV_SBOX = {
        128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
        128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
        128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
        128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
        128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
        128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
        128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
        128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d
    };

    // Multiply by x in GF(2^8).
    function automatic logic [7:0] xt(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // Byte substitution over the whole state.
    function automatic t_state subst_state(input t_state s, input logic inv);
        t_state t;
        for (int i = 0; i < 32; i++) begin
            t[i] = inv ? INV_SBOX[s[i]] : SBOX[s[i]];
        end
        return t;
    endfunction

    // Row rotation for the selected block width.
    function automatic t_state rotate_rows(input t_state s, input logic [1:0] nsel,
                                           input logic inv);
        t_state t;
        t = s;
        if (nsel == SEL_128) begin
            for (int r = 1; r < 4; r++) begin
                for (int c = 0; c < 4; c++) begin
                    if (inv) t[4*((c+r)%4)+r] = s[4*c+r];
                    else     t[4*c+r] = s[4*((c+r)%4)+r];
                end
            end
        end else if (nsel == SEL_192) begin
            for (int r = 1; r < 4; r++) begin
                for (int c = 0; c < 6; c++) begin
                    if (inv) t[4*((c+r)%6)+r] = s[4*c+r];
                    else     t[4*c+r] = s[4*((c+r)%6)+r];
                end
            end
        end else begin
            for (int r = 1; r < 4; r++) begin
                for (int c = 0; c < 8; c++) begin
                    if (inv) t[4*((c+r+(r>1?1:0))%8)+r] = s[4*c+r];
                    else     t[4*c+r] = s[4*((c+r+(r>1?1:0))%8)+r];
                end
            end
        end
        return t;
    endfunction

    // Column mixing on all eight columns; unused columns are masked later.
    function automatic t_state mix_state(input t_state s, input logic inv);
        t_state t;
        logic [7:0] a2 [4];
        logic [7:0] a4 [4];
        logic [7:0] a8 [4];
        logic [7:0] m0 [4];
        logic [7:0] m1 [4];
        logic [7:0] m2 [4];
        logic [7:0] m3 [4];
        for (int c = 0; c < 8; c++) begin
            for (int k = 0; k < 4; k++) begin
                a2[k] = xt(s[4*c+k]);
                a4[k] = xt(a2[k]);
                a8[k] = xt(a4[k]);
                m0[k] = inv ? (a8[k] ^ a4[k] ^ a2[k]) : a2[k];
                m1[k] = inv ? (a8[k] ^ a2[k] ^ s[4*c+k]) : (a2[k] ^ s[4*c+k]);
                m2[k] = inv ? (a8[k] ^ a4[k] ^ s[4*c+k]) : s[4*c+k];
                m3[k] = inv ? (a8[k] ^ s[4*c+k]) : s[4*c+k];
            end
            for (int r = 0; r < 4; r++) begin
                t[4*c+r] = m0[r] ^ m1[(r+1)%4] ^ m2[(r+2)%4] ^ m3[(r+3)%4];
            end
        end
        return t;
    endfunction

    // Round-key row laid out as state bytes.
    function automatic t_state row_bytes(input t_row w);
        t_state t;
        for (int c = 0; c < 8; c++) begin
            for (int k = 0; k < 4; k++) begin
                t[4*c+k] = w[c][8*(3-k) +: 8];
            end
        end
        return t;
    endfunction

    // Zero the bytes beyond the block width.
    function automatic t_state mask_state(input t_state s, input logic [1:0] nsel);
        t_state t;
        t = s;
        for (int i = 16; i < 32; i++) begin
            if (nsel == SEL_128 || (nsel == SEL_192 && i >= 24)) t[i] = 8'h00;
        end
        return t;
    endfunction

endpackage

@@ sv/rbc_if.sv @@
// Data word channels of the cipher: input blocks and result blocks.
interface rbc_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    rbc_pkg::t_word64   block_0;
    rbc_pkg::t_word64   block_1;
    rbc_pkg::t_word64   block_2;
    rbc_pkg::t_word64   block_3;
    modport source (output valid, mode, block_0, block_1, block_2, block_3, input ready);
    modport sink   (input valid, mode, block_0, block_1, block_2, block_3, output ready);
endinterface

interface rbc_out_if;
    logic               valid;
    logic               ready;
    rbc_pkg::t_word64   result_0;
    rbc_pkg::t_word64   result_1;
    rbc_pkg::t_word64   result_2;
    rbc_pkg::t_word64   result_3;
    modport source (output valid, result_0, result_1, result_2, result_3, input ready);
    modport sink   (input valid, result_0, result_1, result_2, result_3, output ready);
endinterface

@@ sv/rijndael_block_cipher.sv @@
// Rijndael cipher with 128/192/256-bit blocks and keys, one shared round unit.
// After reset or any configuration write, the first word accepted starts a key
// expansion that produces one 32-bit round-key word per cycle into a 16-row
// round-key memory. Each word then passes through a fetch state for the first
// key-row read, a whitening state for the initial key addition, and the rounds
// in the shared round unit, fed by one round-key row read per cycle while the
// last round does not stall. The input is taken again in the cycle after the
// last round. The input is not ready while a word is in work; the finished
// result sits in an output register so the next word can be taken while it
// waits, and the last round of that next word holds until the register is free.
// Configuration must be written only while the block is idle; the block itself
// does not enforce this.
`include "rijndael_block_cipher_macros.svh"

module rijndael_block_cipher (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rbc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  rbc_pkg::t_word64                  i_cfg_data,
    rbc_in_if.sink                            i_in,
    rbc_out_if.source                         o_out
);
    import rbc_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXPAND = 3'd1;
    localparam logic [2:0] S_FETCH  = 3'd2;
    localparam logic [2:0] S_WHITEN = 3'd3;
    localparam logic [2:0] S_ROUND  = 3'd4;

    logic [1:0]   r_bsel;
    logic [1:0]   r_ksel;
    t_word64      r_key [4];
    logic         r_keys_ready;
    logic [2:0]   r_state;
    logic         r_mode;
    t_state       r_s;
    logic [31:0]  r_win [8];
    t_row         r_rowbuf;
    logic [2:0]   r_col;
    logic [3:0]   r_row;
    logic [2:0]   r_kc;
    logic         r_first;
    logic [7:0]   r_rcon;
    logic [3:0]   r_ridx;
    logic [3:0]   r_cnt;
    t_row         r_rk;
    t_row         rk_mem [16];
    logic         r_out_valid;
    t_state       r_res;

    logic [3:0]   nb_w;
    logic [3:0]   nk_w;
    logic [3:0]   nr;
    logic [31:0]  key_w;
    logic [31:0]  exp_t;
    logic [31:0]  exp_word;
    t_row         n_rowbuf;
    logic         row_done;
    logic         mem_we;
    logic         rd_en;
    logic         last;
    logic         stall;
    logic         in_acc;
    t_state       rk_b;
    t_state       enc_t;
    t_state       enc_n;
    t_state       dec_t;
    t_state       dec_n;
    t_state       n_s;
    logic [3:0]   start_row;
    logic [3:0]   n_ridx;

    // Word counts and round count from the size selects.
    always_comb begin
        nb_w = (r_bsel == SEL_128) ? 4'd4 : ((r_bsel == SEL_192) ? 4'd6 : 4'd8);
        nk_w = (r_ksel == SEL_128) ? 4'd4 : ((r_ksel == SEL_192) ? 4'd6 : 4'd8);
        nr   = ((nb_w > nk_w) ? nb_w : nk_w) + 4'd6;
    end

    // Key schedule: one word per cycle from a sliding window of the last eight words.
    always_comb begin
        key_w = r_kc[0] ? r_key[r_kc[2:1]][31:0] : r_key[r_kc[2:1]][63:32];
        exp_t = r_win[0];
        if (r_kc == 3'd0) begin
            exp_t = sub_word({r_win[0][23:0], r_win[0][31:24]}) ^ {r_rcon, 24'h0};
        end else if (nk_w == 4'd8 && r_kc == 3'd4) begin
            exp_t = sub_word(r_win[0]);
        end
        exp_word = r_first ? key_w : (r_win[nk_w[2:0] - 3'd1] ^ exp_t);
        n_rowbuf = r_rowbuf;
        n_rowbuf[r_col] = exp_word;
        row_done = (r_col == nb_w[2:0] - 3'd1) || (nb_w == 4'd8 && r_col == 3'd7);
        mem_we   = (r_state == S_EXPAND) && row_done;
    end

    // Shared round unit.
    always_comb begin
        last  = (r_cnt == nr);
        rk_b  = row_bytes(r_rk);
        enc_t = rotate_rows(subst_state(r_s, 1'b0), r_bsel, 1'b0);
        enc_n = (last ? enc_t : mix_state(enc_t, 1'b0)) ^ rk_b;
        dec_t = subst_state(rotate_rows(r_s, r_bsel, 1'b1), 1'b1) ^ rk_b;
        dec_n = last ? dec_t : mix_state(dec_t, 1'b1);
        n_s   = (r_mode == MODE_DEC) ? dec_n : enc_n;
        stall = (r_state == S_ROUND) && last && r_out_valid && !o_out.ready;
        rd_en = (r_state == S_FETCH) || (r_state == S_WHITEN) ||
                ((r_state == S_ROUND) && !stall);
        n_ridx = (r_mode == MODE_DEC) ? (r_ridx - 4'd1) : (r_ridx + 4'd1);
        in_acc = i_in.valid && i_in.ready;
        start_row = (i_in.mode == MODE_DEC) ? nr : 4'd0;
    end

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.result_0 = r_res[0:7];
    assign o_out.result_1 = r_res[8:15];
    assign o_out.result_2 = r_res[16:23];
    assign o_out.result_3 = r_res[24:31];

    // Round-key memory: rows written during expansion, one row read per cycle while rd_en is set.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            rk_mem[r_row] <= n_rowbuf;
        end
        if (rd_en) begin
            r_rk <= rk_mem[r_ridx];
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bsel <= 2'd0;
            r_ksel <= 2'd0;
            for (int k = 0; k < 4; k++) r_key[k] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BSEL: r_bsel   <= i_cfg_data[1:0];
                CFG_KSEL: r_ksel   <= i_cfg_data[1:0];
                CFG_KEY0: r_key[0] <= i_cfg_data;
                CFG_KEY1: r_key[1] <= i_cfg_data;
                CFG_KEY2: r_key[2] <= i_cfg_data;
                CFG_KEY3: r_key[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_keys_ready <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // The output register fills at the end of the last round and empties when taken.
            if (r_state == S_ROUND && last && !stall) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            // Round keys are stale after any register write and valid after the last row.
            if (i_cfg_we && i_cfg_idx <= CFG_KEY3) begin
                r_keys_ready <= 1'b0;
            end else if (r_state == S_EXPAND && row_done && r_row == nr) begin
                r_keys_ready <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_mode <= i_in.mode;
                        r_s    <= {i_in.block_0, i_in.block_1, i_in.block_2, i_in.block_3};
                        r_ridx <= start_row;
                        r_col  <= 3'd0;
                        r_row  <= 4'd0;
                        r_kc   <= 3'd0;
                        r_first <= 1'b1;
                        r_rcon <= 8'h01;
                        r_state <= r_keys_ready ? S_FETCH : S_EXPAND;
                    end
                end
                S_EXPAND: begin
                    r_win[0] <= exp_word;
                    for (int k = 1; k < 8; k++) r_win[k] <= r_win[k-1];
                    if (!r_first && r_kc == 3'd0) r_rcon <= xt(r_rcon);
                    if (r_kc == nk_w[2:0] - 3'd1) begin
                        r_kc    <= 3'd0;
                        r_first <= 1'b0;
                    end else begin
                        r_kc <= r_kc + 3'd1;
                    end
                    r_rowbuf <= n_rowbuf;
                    if (row_done) begin
                        r_col <= 3'd0;
                        r_row <= r_row + 4'd1;
                        if (r_row == nr) begin
                            r_ridx  <= (r_mode == MODE_DEC) ? nr : 4'd0;
                            r_state <= S_FETCH;
                        end
                    end else begin
                        r_col <= r_col + 3'd1;
                    end
                end
                S_FETCH: begin
                    r_ridx  <= n_ridx;
                    r_state <= S_WHITEN;
                end
                S_WHITEN: begin
                    r_s     <= r_s ^ rk_b;
                    r_ridx  <= n_ridx;
                    r_cnt   <= 4'd1;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    if (!stall) begin
                        r_s    <= n_s;
                        r_ridx <= n_ridx;
                        r_cnt  <= r_cnt + 4'd1;
                        if (last) begin
                            r_res   <= mask_state(n_s, r_bsel);
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `RBC_ASSERT_NEXT(a_expand_first, i_clk, i_rst_n, in_acc && !r_keys_ready, r_state == S_EXPAND, "word accepted without round keys did not start expansion")
    `RBC_ASSERT(a_result_from_round, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == S_ROUND), "result appeared outside the last round")
    `RBC_ASSERT(a_round_bound, i_clk, i_rst_n, (r_state == S_ROUND) |-> (r_cnt <= nr), "round counter ran past the round count")

endmodule
